// ===== src/nps_pkg.sv =====
package nps_pkg;

   // Number format and derived widths
   localparam int COORD_FRAC_BITS = 8;
   localparam int COORD_W   = 24;   // signed coordinate
   localparam int DIFF_W    = 25;   // difference of two coordinates
   localparam int CLEAR_W   = 25;   // clearance result
   localparam int DIST_W    = 50;   // stored squared distance, n.n, dot
   localparam int SUM_W     = 52;   // sum of three squares
   localparam int PROD_W    = 74;   // |n| * dot
   localparam int ACC_W     = 76;   // signed main accumulator
   localparam int MUL_STEPS = 24;   // multiplier bits, one per cycle
   localparam int QUO_W     = 24;   // quotient bits, one per cycle
   localparam int ROOT_STEPS = 25;  // root bits, one per cycle
   localparam int REM_W     = 28;   // square root remainder
   localparam int CNT_W     = 5;    // step counter width

   localparam logic [63:0] DIST_CAP = 64'h3FFFFFFFFFFFF;

   // No-hit limit: 1e10 square units, scaled and saturated to the state width
   function automatic logic [DIST_W-1:0] hit_limit();
      logic [63:0] v;
      v = 64'd10000000000;
      for (int i = 0; i < 2 * COORD_FRAC_BITS; i++) begin
         v = (v > (DIST_CAP >> 1)) ? DIST_CAP : (v << 1);
      end
      if (v > DIST_CAP) begin
         v = DIST_CAP;
      end
      return v[DIST_W-1:0];
   endfunction

   localparam logic [DIST_W-1:0]  HIT_LIMIT    = hit_limit();
   localparam logic [CLEAR_W-1:0] NO_HIT_CLEAR = CLEAR_W'(64'd100000 << COORD_FRAC_BITS);

   typedef struct packed {
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] query_z;
      logic signed [COORD_W-1:0] seg_start_x;
      logic signed [COORD_W-1:0] seg_start_y;
      logic signed [COORD_W-1:0] seg_start_z;
      logic signed [COORD_W-1:0] seg_end_x;
      logic signed [COORD_W-1:0] seg_end_y;
      logic signed [COORD_W-1:0] seg_end_z;
      logic                      last_segment;
   } req_payload_type;

   typedef struct packed {
      logic [CLEAR_W-1:0]        clearance;
      logic signed [COORD_W-1:0] nearest_x;
      logic signed [COORD_W-1:0] nearest_y;
      logic signed [COORD_W-1:0] nearest_z;
      logic                      found;
   } rsp_payload_type;

   // Command to the serial multiply-accumulate unit
   typedef struct packed {
      logic start;
      logic clear;
      logic neg;
   } mac_cmd_type;

endpackage

// ===== src/nps_req_if.sv =====
interface nps_req_if;
   logic                     valid;
   logic                     ready;
   nps_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/nps_rsp_if.sv =====
interface nps_rsp_if;
   logic                     valid;
   logic                     ready;
   nps_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/nps_mac.sv =====
// Bit-serial multiply-accumulate, two lanes sharing one multiplier shift register
module nps_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  nps_pkg::mac_cmd_type               cmd,
   input  logic signed [nps_pkg::ACC_W-1:0]   mcand0,
   input  logic [nps_pkg::MUL_STEPS-1:0]      mcand1,
   input  logic [nps_pkg::MUL_STEPS-1:0]      mplier,
   output logic                               busy,
   output logic                               done,
   output logic signed [nps_pkg::ACC_W-1:0]   acc0,
   output logic [nps_pkg::SUM_W-1:0]          acc1
);

   localparam logic [nps_pkg::CNT_W-1:0] STEP_LAST = nps_pkg::CNT_W'(nps_pkg::MUL_STEPS - 1);

   logic signed [nps_pkg::ACC_W-1:0] a0_ff, a0_in, acc0_ff, acc0_in;
   logic [nps_pkg::SUM_W-1:0]        a1_ff, a1_in, acc1_ff, acc1_in;
   logic [nps_pkg::MUL_STEPS-1:0]    b_ff, b_in;
   logic [nps_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                             busy_ff, busy_in, neg_ff, neg_in;

   // next state: load on start, then one multiplier bit per cycle
   always_comb begin
      a0_in   = a0_ff;
      a1_in   = a1_ff;
      acc0_in = acc0_ff;
      acc1_in = acc1_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         a0_in   = mcand0;
         a1_in   = nps_pkg::SUM_W'(mcand1);
         b_in    = mplier;
         cnt_in  = '0;
         busy_in = 1'b1;
         neg_in  = cmd.neg;
         if (cmd.clear) begin
            acc0_in = '0;
            acc1_in = '0;
         end
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc0_in = neg_ff ? (acc0_ff - a0_ff) : (acc0_ff + a0_ff);
            acc1_in = acc1_ff + a1_ff;
         end
         a0_in  = a0_ff <<< 1;
         a1_in  = a1_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a0_ff   <= a0_in;
      a1_ff   <= a1_in;
      acc0_ff <= acc0_in;
      acc1_ff <= acc1_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
   end

   assign busy = busy_ff;
   assign done = busy_ff && (cnt_ff == STEP_LAST);
   assign acc0 = acc0_ff;
   assign acc1 = acc1_ff;

endmodule

// ===== src/nps_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W bits
// and is presented together with done
module nps_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [nps_pkg::PROD_W-1:0]      dividend,
   input  logic [nps_pkg::DIST_W-1:0]      divisor,
   output logic                            done,
   output logic [nps_pkg::QUO_W-1:0]       quotient
);

   localparam logic [nps_pkg::CNT_W-1:0] STEP_LAST = nps_pkg::CNT_W'(nps_pkg::QUO_W - 1);

   logic [nps_pkg::DIST_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [nps_pkg::QUO_W-1:0]  low_ff, low_in;
   logic [nps_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic [nps_pkg::DIST_W:0]   trial, diff;
   logic                       fits;

   // trial subtract of the divisor from the shifted remainder
   assign trial = {rem_ff, low_ff[nps_pkg::QUO_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   // low bits of the dividend shift out as quotient bits shift in
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend[nps_pkg::PROD_W-1 -: nps_pkg::DIST_W];
         low_in  = dividend[nps_pkg::QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[nps_pkg::DIST_W-1:0] : trial[nps_pkg::DIST_W-1:0];
         low_in = {low_ff[nps_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
   end

   // last quotient bit joins in the done cycle
   assign done     = busy_ff && (cnt_ff == STEP_LAST);
   assign quotient = {low_ff[nps_pkg::QUO_W-2:0], fits};

endmodule

// ===== src/nps_isqrt.sv =====
// Floor square root, two radicand bits in and one root bit out per cycle
module nps_isqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [nps_pkg::DIST_W-1:0]      radicand,
   output logic                            done,
   output logic [nps_pkg::CLEAR_W-1:0]     root
);

   localparam logic [nps_pkg::CNT_W-1:0] STEP_LAST =
      nps_pkg::CNT_W'(nps_pkg::ROOT_STEPS - 1);

   logic [nps_pkg::DIST_W-1:0]  rad_ff, rad_in;
   logic [nps_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [nps_pkg::CLEAR_W-1:0] root_ff, root_in;
   logic [nps_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic [nps_pkg::REM_W+1:0]   shifted, trial, diff;
   logic                        fits;

   // compare remainder against 4*root + 1
   assign shifted = {rem_ff, rad_ff[nps_pkg::DIST_W-1 -: 2]};
   assign trial   = (nps_pkg::REM_W+2)'({root_ff, 2'b01});
   assign fits    = shifted >= trial;
   assign diff    = shifted - trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = fits ? diff[nps_pkg::REM_W-1:0] : shifted[nps_pkg::REM_W-1:0];
         root_in = {root_ff[nps_pkg::CLEAR_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == STEP_LAST);
   assign root = root_ff;

endmodule

// ===== src/nearest_point_on_segment_set.sv =====
//  Channel   Dir  Handshake      Payload
//  req_ch    in   valid/ready    query, segment start and end, last_segment
//  rsp_ch    out  valid/ready    clearance, nearest point, found
//
//  One segment at a time. Projection: one pass per axis on the bit-serial MAC
//  for dot and n.n together; interior case adds a multiply and a divide per
//  axis. Distance: one MAC pass per axis. An end that is nearest skips the
//  multiply and divide; the last segment of a run adds the bit-serial square
//  root, when a hit was recorded, and the load of the output register.
//  Synchronous active-high reset; best distance returns to the no-hit limit.
//  A finished result waits in the output register; the next segment is taken
//  meanwhile and only the final transfer of a run waits for that register.
module nearest_point_on_segment_set (
   input  logic       clock,
   input  logic       reset,
   nps_req_if.sink    req_ch,
   nps_rsp_if.source  rsp_ch
);

   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_DOT_GO    = 14'b00000000000010,
      S_DOT_WAIT  = 14'b00000000000100,
      S_CLASS     = 14'b00000000001000,
      S_PROD_GO   = 14'b00000000010000,
      S_PROD_WAIT = 14'b00000000100000,
      S_DIV_GO    = 14'b00000001000000,
      S_DIV_WAIT  = 14'b00000010000000,
      S_DIST_GO   = 14'b00000100000000,
      S_DIST_WAIT = 14'b00001000000000,
      S_UPDATE    = 14'b00010000000000,
      S_SQRT_GO   = 14'b00100000000000,
      S_SQRT_WAIT = 14'b01000000000000,
      S_EMIT      = 14'b10000000000000
   } state_type;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   logic signed [nps_pkg::COORD_W-1:0] p_ff [3], p_in [3];
   logic signed [nps_pkg::COORD_W-1:0] s_ff [3], s_in [3];
   logic signed [nps_pkg::COORD_W-1:0] e_ff [3], e_in [3];
   logic signed [nps_pkg::COORD_W-1:0] c_ff [3], c_in [3];
   logic signed [nps_pkg::COORD_W-1:0] bp_ff [3], bp_in [3];
   logic                               last_ff, last_in;
   logic [nps_pkg::DIST_W-1:0]         dot_ff, dot_in, nn_ff, nn_in;
   logic [nps_pkg::DIST_W-1:0]         best_ff, best_in;
   logic                               any_ff, any_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   nps_pkg::rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   // serial units
   nps_pkg::mac_cmd_type               mac_cmd;
   logic signed [nps_pkg::ACC_W-1:0]   mac_mcand0, mac_acc0;
   logic [nps_pkg::MUL_STEPS-1:0]      mac_mcand1, mac_mplier;
   logic [nps_pkg::SUM_W-1:0]          mac_acc1;
   logic                               mac_busy, mac_done;
   logic                               div_start, div_done;
   logic [nps_pkg::QUO_W-1:0]          div_quo;
   logic                               sqrt_start, sqrt_done;
   logic [nps_pkg::CLEAR_W-1:0]        sqrt_root;

   // per-axis operands
   logic signed [nps_pkg::COORD_W-1:0] ax_p, ax_s, ax_e, ax_c;
   logic signed [nps_pkg::DIFF_W-1:0]  ax_n, ax_q, ax_d, ax_off, ax_csum;
   logic [nps_pkg::DIFF_W-1:0]         ax_nabs, ax_dabs;
   logic [nps_pkg::MUL_STEPS-1:0]      ax_nmag, ax_dmag;
   logic                               dot_le0, dot_ge_nn, hit, req_xfer;
   logic [nps_pkg::SUM_W-1:0]          dist_sum;

   assign ax_p = p_ff[axis_ff];
   assign ax_s = s_ff[axis_ff];
   assign ax_e = e_ff[axis_ff];
   assign ax_c = c_ff[axis_ff];

   assign ax_n    = {ax_e[nps_pkg::COORD_W-1], ax_e} - {ax_s[nps_pkg::COORD_W-1], ax_s};
   assign ax_q    = {ax_p[nps_pkg::COORD_W-1], ax_p} - {ax_s[nps_pkg::COORD_W-1], ax_s};
   assign ax_d    = {ax_c[nps_pkg::COORD_W-1], ax_c} - {ax_p[nps_pkg::COORD_W-1], ax_p};
   assign ax_nabs = ax_n[nps_pkg::DIFF_W-1] ? -ax_n : ax_n;
   assign ax_dabs = ax_d[nps_pkg::DIFF_W-1] ? -ax_d : ax_d;
   assign ax_nmag = ax_nabs[nps_pkg::MUL_STEPS-1:0];
   assign ax_dmag = ax_dabs[nps_pkg::MUL_STEPS-1:0];

   // interior point: start plus signed truncated offset
   assign ax_off  = ax_n[nps_pkg::DIFF_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   assign ax_csum = {ax_s[nps_pkg::COORD_W-1], ax_s} + ax_off;

   // projection classification
   assign dot_le0   = mac_acc0[nps_pkg::ACC_W-1] || (mac_acc0 == '0);
   assign dot_ge_nn = mac_acc0[nps_pkg::ACC_W-2:0] >= (nps_pkg::ACC_W-1)'(mac_acc1);

   assign dist_sum = mac_acc0[nps_pkg::SUM_W-1:0];
   assign hit      = dist_sum < nps_pkg::SUM_W'(best_ff);
   assign req_xfer = req_ch.valid && req_ch.ready;

   // unit commands
   always_comb begin
      mac_cmd    = '0;
      mac_mcand0 = nps_pkg::ACC_W'(ax_q);
      mac_mcand1 = ax_nmag;
      mac_mplier = ax_nmag;
      if (state_ff == S_DOT_GO) begin
         mac_cmd.start = 1'b1;
         mac_cmd.clear = (axis_ff == '0);
         mac_cmd.neg   = ax_n[nps_pkg::DIFF_W-1];
      end else if (state_ff == S_PROD_GO) begin
         mac_cmd.start = 1'b1;
         mac_cmd.clear = 1'b1;
         mac_mcand0    = $signed(nps_pkg::ACC_W'(dot_ff));
      end else if (state_ff == S_DIST_GO) begin
         mac_cmd.start = 1'b1;
         mac_cmd.clear = (axis_ff == '0);
         mac_mcand0    = $signed(nps_pkg::ACC_W'(ax_dmag));
         mac_mplier    = ax_dmag;
      end
   end

   assign div_start  = (state_ff == S_DIV_GO);
   assign sqrt_start = (state_ff == S_SQRT_GO);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      axis_in        = axis_ff;
      p_in           = p_ff;
      s_in           = s_ff;
      e_in           = e_ff;
      c_in           = c_ff;
      bp_in          = bp_ff;
      last_in        = last_ff;
      dot_in         = dot_ff;
      nn_in          = nn_ff;
      best_in        = best_ff;
      any_in         = any_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               p_in[0] = req_ch.payload.query_x;
               p_in[1] = req_ch.payload.query_y;
               p_in[2] = req_ch.payload.query_z;
               s_in[0] = req_ch.payload.seg_start_x;
               s_in[1] = req_ch.payload.seg_start_y;
               s_in[2] = req_ch.payload.seg_start_z;
               e_in[0] = req_ch.payload.seg_end_x;
               e_in[1] = req_ch.payload.seg_end_y;
               e_in[2] = req_ch.payload.seg_end_z;
               last_in = req_ch.payload.last_segment;
               axis_in = '0;
               state_in = S_DOT_GO;
            end
         end
         S_DOT_GO: state_in = S_DOT_WAIT;
         S_DOT_WAIT: begin
            if (mac_done) begin
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_CLASS;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_DOT_GO;
               end
            end
         end
         S_CLASS: begin
            dot_in  = mac_acc0[nps_pkg::DIST_W-1:0];
            nn_in   = mac_acc1[nps_pkg::DIST_W-1:0];
            axis_in = '0;
            if (dot_le0) begin
               c_in     = s_ff;
               state_in = S_DIST_GO;
            end else if (dot_ge_nn) begin
               c_in     = e_ff;
               state_in = S_DIST_GO;
            end else begin
               state_in = S_PROD_GO;
            end
         end
         S_PROD_GO: state_in = S_PROD_WAIT;
         S_PROD_WAIT: begin
            if (mac_done) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_done) begin
               c_in[axis_ff] = ax_csum[nps_pkg::COORD_W-1:0];
               if (axis_ff == AXIS_LAST) begin
                  axis_in  = '0;
                  state_in = S_DIST_GO;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_PROD_GO;
               end
            end
         end
         S_DIST_GO: state_in = S_DIST_WAIT;
         S_DIST_WAIT: begin
            if (mac_done) begin
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_UPDATE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_DIST_GO;
               end
            end
         end
         S_UPDATE: begin
            if (hit) begin
               best_in = dist_sum[nps_pkg::DIST_W-1:0];
               bp_in   = c_ff;
               any_in  = 1'b1;
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (hit || any_ff) begin
               state_in = S_SQRT_GO;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SQRT_GO: state_in = S_SQRT_WAIT;
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // wait for the output register to drain, then load and clear the run
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               if (any_ff) begin
                  rsp_payload_in.clearance = sqrt_root;
                  rsp_payload_in.nearest_x = bp_ff[0];
                  rsp_payload_in.nearest_y = bp_ff[1];
                  rsp_payload_in.nearest_z = bp_ff[2];
                  rsp_payload_in.found     = 1'b1;
               end else begin
                  rsp_payload_in.clearance = nps_pkg::NO_HIT_CLEAR;
                  rsp_payload_in.nearest_x = '0;
                  rsp_payload_in.nearest_y = '0;
                  rsp_payload_in.nearest_z = '0;
                  rsp_payload_in.found     = 1'b0;
               end
               best_in  = nps_pkg::HIT_LIMIT;
               bp_in    = '{default: '0};
               any_in   = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         best_ff      <= nps_pkg::HIT_LIMIT;
         bp_ff        <= '{default: '0};
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         best_ff      <= best_in;
         bp_ff        <= bp_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff           <= p_in;
      s_ff           <= s_in;
      e_ff           <= e_in;
      c_ff           <= c_in;
      last_ff        <= last_in;
      dot_ff         <= dot_in;
      nn_ff          <= nn_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   nps_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mac_cmd),
      .mcand0 (mac_mcand0),
      .mcand1 (mac_mcand1),
      .mplier (mac_mplier),
      .busy   (mac_busy),
      .done   (mac_done),
      .acc0   (mac_acc0),
      .acc1   (mac_acc1)
   );

   nps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mac_acc0[nps_pkg::PROD_W-1:0]),
      .divisor  (nn_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   nps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (best_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // MAC is never left running while waiting for a segment
   a_idle_mac_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mac_busy)
      else $error("MAC busy while idle");

   // no hit recorded means the best distance still sits at the limit
   a_no_hit_limit: assert property (@(posedge clock) disable iff (reset)
      !any_ff |-> (best_ff == nps_pkg::HIT_LIMIT))
      else $error("best distance moved without a hit");

   // a pending no-hit result carries the fixed clearance
   a_no_hit_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.found) |->
         (rsp_payload_ff.clearance == nps_pkg::NO_HIT_CLEAR))
      else $error("no-hit result with wrong clearance");

   // an accepted segment starts the projection next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_DOT_GO))
      else $error("accepted segment not started");

endmodule

// ===== test/nearest_point_on_segment_set_tb.sv =====
`timescale 1ns / 100ps

module nearest_point_on_segment_set_tb;

   logic clock = 1'b0;
   logic reset;

   nps_req_if req_ch ();
   nps_rsp_if rsp_ch ();

   nearest_point_on_segment_set DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 400;

   // Running state of the segment search, kept in step with the block
   logic [nps_pkg::DIST_W-1:0]         best_dist;
   logic signed [nps_pkg::COORD_W-1:0] best_pt [3];
   logic                               best_valid;

   nps_pkg::rsp_payload_type clearance_queue [$];

   int error_count = 0;
   int segment_count;
   int result_count = 0;
   int found_count = 0;
   int idle_cycles = 0;
   bit quiet_mode;

   always #5 clock = ~clock;

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void clear_search();
      best_dist  = nps_pkg::HIT_LIMIT;
      best_pt[0] = '0;
      best_pt[1] = '0;
      best_pt[2] = '0;
      best_valid = 1'b0;
   endfunction

   // Projects the query onto one segment and folds it into the running best
   function automatic void measure_segment(nps_pkg::req_payload_type seg);
      longint     p [3];
      longint     s [3];
      longint     e [3];
      longint     n [3];
      longint     c [3];
      longint     dot;
      longint     nn;
      longint     d;
      logic [63:0] dist_acc;
      logic [127:0] prod;
      longint     off;
      nps_pkg::rsp_payload_type rsp;
      p[0] = seg.query_x;     p[1] = seg.query_y;     p[2] = seg.query_z;
      s[0] = seg.seg_start_x; s[1] = seg.seg_start_y; s[2] = seg.seg_start_z;
      e[0] = seg.seg_end_x;   e[1] = seg.seg_end_y;   e[2] = seg.seg_end_z;
      dot      = 0;
      nn       = 0;
      dist_acc = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = e[i] - s[i];
         dot  = dot + (p[i] - s[i]) * n[i];
         nn   = nn + n[i] * n[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (dot <= 0) begin
            c[i] = s[i];
         end else if (dot >= nn) begin
            c[i] = e[i];
         end else begin
            // interior: truncate the offset toward zero
            prod = 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(dot);
            off  = longint'(prod / 128'(nn));
            c[i] = s[i] + (n[i] < 0 ? -off : off);
         end
         d        = c[i] - p[i];
         dist_acc = dist_acc + 64'(d * d);
      end
      if (dist_acc < 64'(best_dist)) begin
         best_dist  = dist_acc[nps_pkg::DIST_W-1:0];
         best_pt[0] = c[0][nps_pkg::COORD_W-1:0];
         best_pt[1] = c[1][nps_pkg::COORD_W-1:0];
         best_pt[2] = c[2][nps_pkg::COORD_W-1:0];
         best_valid = 1'b1;
      end
      if (seg.last_segment) begin
         if (best_valid) begin
            rsp.clearance = nps_pkg::CLEAR_W'(floor_root(64'(best_dist)));
            rsp.nearest_x = best_pt[0];
            rsp.nearest_y = best_pt[1];
            rsp.nearest_z = best_pt[2];
            rsp.found     = 1'b1;
         end else begin
            rsp.clearance = nps_pkg::NO_HIT_CLEAR;
            rsp.nearest_x = '0;
            rsp.nearest_y = '0;
            rsp.nearest_z = '0;
            rsp.found     = 1'b0;
         end
         clearance_queue = {clearance_queue, rsp};
         clear_search();
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Send one segment; gaps only before the transfer
   task automatic send_segment(nps_pkg::req_payload_type seg);
      if (!quiet_mode && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= seg;
      do @(posedge clock); while (!req_ch.ready);
      measure_segment(seg);
      segment_count++;
   endtask

   function automatic nps_pkg::req_payload_type make_seg(
      longint qx, longint qy, longint qz, longint sx, longint sy, longint sz,
      longint ex, longint ey, longint ez, bit last);
      nps_pkg::req_payload_type seg;
      seg.query_x     = qx[nps_pkg::COORD_W-1:0];
      seg.query_y     = qy[nps_pkg::COORD_W-1:0];
      seg.query_z     = qz[nps_pkg::COORD_W-1:0];
      seg.seg_start_x = sx[nps_pkg::COORD_W-1:0];
      seg.seg_start_y = sy[nps_pkg::COORD_W-1:0];
      seg.seg_start_z = sz[nps_pkg::COORD_W-1:0];
      seg.seg_end_x   = ex[nps_pkg::COORD_W-1:0];
      seg.seg_end_y   = ey[nps_pkg::COORD_W-1:0];
      seg.seg_end_z   = ez[nps_pkg::COORD_W-1:0];
      seg.last_segment = last;
      return seg;
   endfunction

   function automatic longint rand_coord();
      return longint'($signed(24'($urandom)));
   endfunction

   function automatic longint near_coord(longint base, int span);
      longint v;
      v = base + $signed($urandom_range(2 * span)) - span;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
   endfunction

   // Start, end and zero-length cases
   task automatic test_endpoints();
      send_segment(make_seg(0, 0, 0, 256, 256, 0, 512, 512, 0, 0));
      send_segment(make_seg(0, 0, 0, -512, 0, 0, -256, 0, 0, 0));
      send_segment(make_seg(100, 200, 300, 100, 200, 300, 100, 200, 300, 1));
      send_segment(make_seg(-7, 9, 11, 50, -40, 30, 50, -40, 30, 1));
   endtask

   // Projection falls strictly inside the segment; one full-range case lands on the end
   task automatic test_interior();
      send_segment(make_seg(128, 700, -3, 0, 0, 0, 1000, 0, 0, 0));
      send_segment(make_seg(-333, 41, 77, 500, 500, 500, -500, -500, -501, 0));
      send_segment(make_seg(5, 5, 5, -9, 17, 3, 31, -2, 8, 1));
      send_segment(make_seg(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                            8388607, 8388607, 8388606, 1));
      send_segment(make_seg(-8388608, 8388607, 0, -8388608, -8388608, 8388607,
                            8388607, 8388607, -8388608, 1));
   endtask

   // Everything out of range gives the no-hit result; then a tie
   task automatic test_no_hit();
      send_segment(make_seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                            8388607, 8388607, 8388607, 0));
      send_segment(make_seg(-8388608, -8388608, -8388608, 8388607, 8388607, 8388600,
                            8388600, 8388607, 8388607, 1));
      send_segment(make_seg(10, 10, 10, 20, 10, 10, 30, 10, 10, 0));
      send_segment(make_seg(10, 10, 10, 0, 10, 10, -30, 10, 10, 1));
   endtask

   // Query carried by each item may differ inside one run
   task automatic test_query_change();
      send_segment(make_seg(0, 0, 0, 1000, 0, 0, 1000, 100, 0, 0));
      send_segment(make_seg(5000, 0, 0, 1000, 0, 0, 1000, 100, 0, 0));
      send_segment(make_seg(-5000, 40, 0, -4000, 0, 0, -4000, 100, 0, 1));
   endtask

   // Runs of random length: mostly segments near the query, some full range
   task automatic test_random_runs(int target);
      int     run_len;
      longint q [3];
      longint s [3];
      int     span;
      bit     wide;
      while (segment_count < target) begin
         run_len = $urandom_range(1, 8);
         q[0] = rand_coord(); q[1] = rand_coord(); q[2] = rand_coord();
         for (int k = 0; k < run_len; k++) begin
            wide = ($urandom_range(99) < 20);
            span = wide ? 0 : (1 << $urandom_range(4, 20));
            if ($urandom_range(99) < 10) begin
               q[0] = rand_coord(); q[1] = rand_coord(); q[2] = rand_coord();
            end
            for (int i = 0; i < 3; i++) s[i] = wide ? rand_coord() : near_coord(q[i], span);
            if (wide) begin
               send_segment(make_seg(q[0], q[1], q[2], s[0], s[1], s[2],
                                     rand_coord(), rand_coord(), rand_coord(),
                                     k == run_len - 1));
            end else begin
               send_segment(make_seg(q[0], q[1], q[2], s[0], s[1], s[2],
                                     near_coord(q[0], span), near_coord(q[1], span),
                                     near_coord(q[2], span), k == run_len - 1));
            end
         end
      end
   endtask

   // Result checking, random back-pressure and the stall watchdog
   always @(posedge clock) begin
      nps_pkg::rsp_payload_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (clearance_queue.size() == 0) begin
               $display("unexpected result at %0t", $realtime);
               error_count++;
            end else begin
               want = clearance_queue.pop_front();
               if (rsp_ch.payload.clearance != want.clearance)
                  report_mismatch("clearance", rsp_ch.payload.clearance, want.clearance);
               if (rsp_ch.payload.nearest_x != want.nearest_x)
                  report_mismatch("nearest_x", rsp_ch.payload.nearest_x, want.nearest_x);
               if (rsp_ch.payload.nearest_y != want.nearest_y)
                  report_mismatch("nearest_y", rsp_ch.payload.nearest_y, want.nearest_y);
               if (rsp_ch.payload.nearest_z != want.nearest_z)
                  report_mismatch("nearest_z", rsp_ch.payload.nearest_z, want.nearest_z);
               if (rsp_ch.payload.found != want.found)
                  report_mismatch("found", rsp_ch.payload.found, want.found);
               result_count++;
               if (want.found) found_count++;
            end
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
      rsp_ch.ready <= quiet_mode || ($urandom_range(99) >= 33);
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      segment_count  = 0;
      quiet_mode     = 1'b0;
      clear_search();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_endpoints();
      test_interior();
      test_no_hit();
      test_query_change();
      test_random_runs(400);
      quiet_mode = 1'b1;
      test_random_runs(550);
      quiet_mode = 1'b0;
      test_random_runs(870);
      req_ch.valid <= 1'b0;

      // drain outstanding results
      while (clearance_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d segments in %0d runs, %0d with a hit and %0d without",
               segment_count, result_count, found_count, result_count - found_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
